// ===== hw/rtl/fca_pkg.sv =====
// fca_pkg: shared types and codes of the chain allocator
// controller state, command and status groups, field codes
// no dependencies
`timescale 1ns / 1ps

package fca_pkg;

  // input mode codes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_ALLOC = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_FREE = 2'd1;
  localparam logic [1:0] STAT_TRUNC   = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_MARK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_MARK  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_READ_OUT,
    ST_NORM,
    ST_SEEK,
    ST_SCAN,
    ST_TAKE,
    ST_FAIL,
    ST_EMIT_A,
    ST_EMIT_B,
    ST_EMIT_C
  } state_t;

  // table read address source
  typedef enum logic [1:0] {
    RSEL_IDX,
    RSEL_SCAN,
    RSEL_CHAIN
  } rsel_t;

  // result register source
  typedef enum logic [2:0] {
    OSEL_NONE,
    OSEL_WRITE,
    OSEL_READ,
    OSEL_FAIL,
    OSEL_CHAIN
  } osel_t;

  typedef struct packed {
    logic  load;
    logic  wr_entry;
    logic  norm_sub;
    logic  scan_init;
    logic  scan_step;
    logic  found_take;
    logic  take;
    logic  set_trunc;
    logic  emit_init;
    logic  emit_next;
    rsel_t rsel;
    osel_t osel;
  } cmd_t;

  typedef struct packed {
    logic hint_lt;
    logic found;
    logic miss;
    logic first;
    logic rem_done;
    logic cap;
    logic k_last;
  } sts_t;

endpackage

// ===== hw/rtl/fca_ram.sv =====
// fca_ram: generic single write port, single read port memory
// read data registered; no dependencies
`timescale 1ns / 1ps

module fca_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/fca_ctrl.sv =====
// fca_ctrl: sequencer of the chain allocator
// issues datapath commands from the datapath status; uses fca_pkg
`timescale 1ns / 1ps

module fca_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [1:0]      in_mode,
  input  fca_pkg::sts_t   sts,
  output fca_pkg::cmd_t   cmd,
  output logic            busy
);

  import fca_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_mode)
            MODE_WRITE: state_nxt = ST_WRITE;
            MODE_READ:  state_nxt = ST_READ;
            MODE_ALLOC: state_nxt = ST_NORM;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WRITE:    state_nxt = ST_IDLE;
      ST_READ:     state_nxt = ST_READ_OUT;
      ST_READ_OUT: state_nxt = ST_IDLE;
      ST_NORM: begin
        if (sts.hint_lt) state_nxt = ST_SEEK;
      end
      ST_SEEK:     state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (sts.found) begin
          state_nxt = ST_TAKE;
        end else if (sts.miss) begin
          state_nxt = sts.first ? ST_FAIL : ST_EMIT_A;
        end
      end
      ST_TAKE: begin
        if (sts.rem_done || sts.cap) begin
          state_nxt = ST_EMIT_A;
        end else begin
          state_nxt = ST_SEEK;
        end
      end
      ST_FAIL:     state_nxt = ST_IDLE;
      ST_EMIT_A:   state_nxt = ST_EMIT_B;
      ST_EMIT_B:   state_nxt = ST_EMIT_C;
      ST_EMIT_C:   state_nxt = sts.k_last ? ST_IDLE : ST_EMIT_A;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    cmd.rsel = RSEL_IDX;
    cmd.osel = OSEL_NONE;
    busy     = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_WRITE: begin
        cmd.wr_entry = 1'b1;
        cmd.osel     = OSEL_WRITE;
      end
      ST_READ:     cmd.rsel = RSEL_IDX;
      ST_READ_OUT: cmd.osel = OSEL_READ;
      ST_NORM:     cmd.norm_sub = !sts.hint_lt;
      ST_SEEK:     cmd.scan_init = 1'b1;
      ST_SCAN: begin
        cmd.rsel = RSEL_SCAN;
        if (sts.found) begin
          cmd.found_take = 1'b1;
        end else if (sts.miss) begin
          cmd.set_trunc = !sts.first;
          cmd.emit_init = !sts.first;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_TAKE: begin
        cmd.take      = 1'b1;
        cmd.emit_init = sts.rem_done || sts.cap;
        cmd.set_trunc = !sts.rem_done && sts.cap;
      end
      ST_FAIL:   cmd.osel = OSEL_FAIL;
      ST_EMIT_A: cmd.rsel = RSEL_CHAIN;
      ST_EMIT_B: cmd.rsel = RSEL_CHAIN;
      ST_EMIT_C: begin
        cmd.osel      = OSEL_CHAIN;
        cmd.emit_next = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

// ===== hw/rtl/fca_dp.sv =====
// fca_dp: datapath of the chain allocator
// table and chain memories, search pointers, byte counters, result registers
// uses fca_pkg and fca_ram
`timescale 1ns / 1ps

module fca_dp #(
  parameter int unsigned TABLE_DEPTH  = 1024,
  parameter int unsigned SECTOR_BYTES = 512,
  parameter int unsigned MAX_CHAIN    = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fca_pkg::cmd_t                 cmd,
  output fca_pkg::sts_t                 sts,
  input  logic [9:0]                    in_entry_index,
  input  logic [15:0]                   in_entry_value,
  input  logic [9:0]                    in_start_hint,
  input  logic [15:0]                   in_byte_count,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [fca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  output logic                          out_valid,
  output logic [9:0]                    out_sector,
  output logic [15:0]                   out_link,
  output logic                          out_last,
  output logic [1:0]                    out_status,
  output logic [15:0]                   out_bytes_placed
);

  import fca_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;
  localparam int unsigned NW = $clog2(MAX_CHAIN + 1);
  localparam int unsigned LW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned XW = AW + 10;
  localparam logic [XW-1:0] DEPTH_X  = XW'(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_PTR = AW'(TABLE_DEPTH - 1);
  localparam logic [LW-1:0] SCAN_ALL = LW'(TABLE_DEPTH);
  localparam logic [LW-1:0] SCAN_REST = LW'(TABLE_DEPTH - 1);
  localparam logic [15:0]   SB16     = 16'(SECTOR_BYTES);
  localparam logic [NW-1:0] CAP_N    = NW'(MAX_CHAIN - 1);

  logic [15:0]   free_mark_r, end_mark_r;
  logic [9:0]    idx_r;
  logic [15:0]   val_r;
  logic [XW-1:0] hint_r;
  logic [15:0]   rem_r, placed_r;
  logic [AW-1:0] cur_r, iss_ptr_r, cmp_ptr_r, sec_r;
  logic          vld_r, first_r, trunc_r;
  logic [LW-1:0] left_r;
  logic [NW-1:0] n_r, k_r;

  logic          out_valid_r, out_last_r;
  logic [9:0]    out_sector_r;
  logic [15:0]   out_link_r, out_bytes_r;
  logic [1:0]    out_status_r;

  logic [XW-1:0] idx_ext, sec_ext;
  logic          idx_in;
  logic [15:0]   take;
  logic [AW-1:0] cur_inc, iss_inc;
  logic          match;

  logic          tbl_we;
  logic [AW-1:0] tbl_waddr, tbl_raddr;
  logic [15:0]   tbl_wdata, tbl_rdata;
  logic [AW-1:0] chn_rdata;

  assign idx_ext = XW'(idx_r);
  assign idx_in  = idx_ext < DEPTH_X;
  assign sec_ext = XW'(sec_r);
  assign take    = (rem_r > SB16) ? SB16 : rem_r;
  assign cur_inc = (cur_r == LAST_PTR) ? '0 : cur_r + 1'b1;
  assign iss_inc = (iss_ptr_r == LAST_PTR) ? '0 : iss_ptr_r + 1'b1;
  assign match   = tbl_rdata == free_mark_r;

  assign sts.hint_lt  = hint_r < DEPTH_X;
  assign sts.found    = vld_r && match;
  assign sts.miss     = vld_r && !match && (left_r == LW'(1));
  assign sts.first    = first_r;
  assign sts.rem_done = rem_r <= SB16;
  assign sts.cap      = n_r == CAP_N;
  assign sts.k_last   = (k_r + NW'(1)) == n_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_mark_r <= 16'h0000;
      end_mark_r  <= 16'hFFFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FREE_MARK: free_mark_r <= cfg_data;
        CFG_END_MARK:  end_mark_r  <= cfg_data;
        default:       free_mark_r <= free_mark_r;
      endcase
    end
  end

  // table write port: entry write, chain link, end mark on taken sector
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = cur_r;
    tbl_wdata = end_mark_r;
    if (cmd.wr_entry) begin
      tbl_we    = idx_in;
      tbl_waddr = idx_ext[AW-1:0];
      tbl_wdata = val_r;
    end else if (cmd.found_take) begin
      tbl_we    = !first_r;
      tbl_wdata = 16'(cmp_ptr_r);
    end else if (cmd.take) begin
      tbl_we    = 1'b1;
    end
  end

  always_comb begin
    case (cmd.rsel)
      RSEL_IDX:   tbl_raddr = idx_ext[AW-1:0];
      RSEL_SCAN:  tbl_raddr = iss_ptr_r;
      RSEL_CHAIN: tbl_raddr = chn_rdata;
      default:    tbl_raddr = idx_ext[AW-1:0];
    endcase
  end

  fca_ram #(
    .WIDTH (16),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (tbl_waddr),
    .wr_data (tbl_wdata),
    .rd_addr (tbl_raddr),
    .rd_data (tbl_rdata)
  );

  // sectors of the chain under construction, in order
  fca_ram #(
    .WIDTH (AW),
    .DEPTH (MAX_CHAIN)
  ) u_chain (
    .clk     (clk),
    .wr_en   (cmd.take),
    .wr_addr (n_r[CW-1:0]),
    .wr_data (cur_r),
    .rd_addr (k_r[CW-1:0]),
    .rd_data (chn_rdata)
  );

  // item registers and search state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r    <= in_entry_index;
      val_r    <= in_entry_value;
      hint_r   <= XW'(in_start_hint);
      rem_r    <= in_byte_count;
      placed_r <= '0;
      first_r  <= 1'b1;
      trunc_r  <= 1'b0;
      n_r      <= '0;
    end
    if (cmd.norm_sub) begin
      hint_r <= hint_r - DEPTH_X;
    end
    if (cmd.scan_init) begin
      iss_ptr_r <= first_r ? hint_r[AW-1:0] : cur_inc;
      left_r    <= first_r ? SCAN_ALL : SCAN_REST;
      vld_r     <= 1'b0;
    end
    if (cmd.scan_step) begin
      iss_ptr_r <= iss_inc;
      cmp_ptr_r <= iss_ptr_r;
      vld_r     <= 1'b1;
      if (vld_r) begin
        left_r <= left_r - LW'(1);
      end
    end
    if (cmd.found_take) begin
      cur_r <= cmp_ptr_r;
    end
    if (cmd.take) begin
      rem_r    <= rem_r - take;
      placed_r <= placed_r + take;
      n_r      <= n_r + NW'(1);
      first_r  <= 1'b0;
    end
    if (cmd.set_trunc) begin
      trunc_r <= 1'b1;
    end
    if (cmd.emit_init) begin
      k_r <= '0;
    end
    if (cmd.emit_next) begin
      k_r <= k_r + NW'(1);
    end
    if (cmd.rsel == RSEL_CHAIN) begin
      sec_r <= chn_rdata;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.osel != OSEL_NONE;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.osel)
      OSEL_WRITE: begin
        out_sector_r <= idx_r;
        out_link_r   <= val_r;
        out_last_r   <= 1'b1;
        out_status_r <= STAT_OK;
        out_bytes_r  <= '0;
      end
      OSEL_READ: begin
        out_sector_r <= idx_r;
        out_link_r   <= idx_in ? tbl_rdata : 16'h0000;
        out_last_r   <= 1'b1;
        out_status_r <= STAT_OK;
        out_bytes_r  <= '0;
      end
      OSEL_FAIL: begin
        out_sector_r <= hint_r[9:0];
        out_link_r   <= 16'h0000;
        out_last_r   <= 1'b1;
        out_status_r <= STAT_NO_FREE;
        out_bytes_r  <= '0;
      end
      OSEL_CHAIN: begin
        out_sector_r <= sec_ext[9:0];
        out_link_r   <= tbl_rdata;
        out_last_r   <= sts.k_last;
        out_status_r <= trunc_r ? STAT_TRUNC : STAT_OK;
        out_bytes_r  <= sts.k_last ? placed_r : 16'h0000;
      end
      default: out_last_r <= out_last_r;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_sector       = out_sector_r;
  assign out_link         = out_link_r;
  assign out_last         = out_last_r;
  assign out_status       = out_status_r;
  assign out_bytes_placed = out_bytes_r;

endmodule

// ===== hw/rtl/fat_chain_allocator.sv =====
// fat_chain_allocator: allocation table with next-fit chain allocation
// top level; joins fca_ctrl and fca_dp, uses fca_pkg
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low; results come back
// as one-cycle strobes on out_valid that the receiver cannot hold off, with
// out_last marking the final result of a command. An allocation first folds
// start_hint into the table by subtracting TABLE_DEPTH until it is below it,
// then for each sector searches the table for a free entry (the search reads
// one entry a cycle through the table memory's single read port, up to
// TABLE_DEPTH entries) and takes the sector; finally, unless no free sector
// was found at all, each result is read back from the chain memory and the
// table. The table comes out of reset undefined: every entry a command may
// reach must be written first. Configuration writes are taken at any cycle,
// but belong between commands.
module fat_chain_allocator #(
  parameter int unsigned TABLE_DEPTH  = 1024,
  parameter int unsigned SECTOR_BYTES = 512,
  parameter int unsigned MAX_CHAIN    = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_mode,
  input  logic [9:0]                    in_entry_index,
  input  logic [15:0]                   in_entry_value,
  input  logic [9:0]                    in_start_hint,
  input  logic [15:0]                   in_byte_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  output logic                          out_valid,
  output logic [9:0]                    out_sector,
  output logic [15:0]                   out_link,
  output logic                          out_last,
  output logic [1:0]                    out_status,
  output logic [15:0]                   out_bytes_placed
);

  import fca_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  fca_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  fca_dp #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .SECTOR_BYTES (SECTOR_BYTES),
    .MAX_CHAIN    (MAX_CHAIN)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_entry_index   (in_entry_index),
    .in_entry_value   (in_entry_value),
    .in_start_hint    (in_start_hint),
    .in_byte_count    (in_byte_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_sector       (out_sector),
    .out_link         (out_link),
    .out_last         (out_last),
    .out_status       (out_status),
    .out_bytes_placed (out_bytes_placed)
  );

endmodule

// ===== hw/rtl/fca_checker.sv =====
// fca_checker: port-level assertions for fat_chain_allocator
// bound to the top level below; uses fca_pkg
`timescale 1ns / 1ps

module fca_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_mode,
  input logic        out_valid,
  input logic [15:0] out_link,
  input logic        out_last,
  input logic [1:0]  out_status,
  input logic [15:0] out_bytes_placed
);

  import fca_pkg::*;

  // a real command keeps the block busy right after its transfer
  a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_mode != MODE_NONE |=> busy)
    else $error("command transfer did not raise busy");

  // more results of a chain follow, so the block stays busy
  a_chain_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> busy)
    else $error("idle before the last result of a chain");

  // a failed allocation is a single empty result
  a_fail_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_NO_FREE |->
      out_last && out_link == 16'h0000 && out_bytes_placed == 16'h0000)
    else $error("malformed no-free result");

  // results only ever come from work under way in the cycle before
  a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && $past(!busy) |-> !out_valid)
    else $error("result strobe while idle");

endmodule

bind fat_chain_allocator fca_checker u_fca_checker (.*);
